/* rtl/omnf_pkg.sv */
// ----------------------------------------------------------------------------
// omnf_pkg
// Shared constants and types of the octree Morton neighbor finder.
// ----------------------------------------------------------------------------
package omnf_pkg;

	localparam int KEY_BITS = 30;
	localparam int AXES     = 3;
	localparam int LEVELS   = KEY_BITS / AXES;
	localparam int LVL_W    = 4;
	localparam int AXIS_W   = 2;
	localparam int NUM_RES  = 2 * AXES;

	localparam logic KIND_SIBLING = 1'b0;
	localparam logic KIND_FACE    = 1'b1;

	localparam logic [LVL_W-1:0] LVL_MIN = LVL_W'(1);
	localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(LEVELS);

	typedef struct packed {
		logic [KEY_BITS-1:0] key;
		logic                kind;
		logic [AXIS_W-1:0]   axis;
	} result_t;

	// key bit of zero-based level lvl0 for axis ax (level 0 is the coarsest)
	function automatic int bit_pos(input int lvl0, input int ax);
		return KEY_BITS - 1 - AXES * lvl0 - ax;
	endfunction

endpackage

/* rtl/omnf_nbr_calc.sv */
// ----------------------------------------------------------------------------
// omnf_nbr_calc
// Builds the sibling and face neighbor keys of one node key at a given level.
// ----------------------------------------------------------------------------
module omnf_nbr_calc
	import omnf_pkg::*;
(
	input  logic [KEY_BITS-1:0] node_key,
	input  logic [LVL_W-1:0]    lvl,
	output result_t             res [NUM_RES],
	output logic [NUM_RES-1:0]  res_vld
);

	logic [LEVELS-1:0] sel;
	logic [LEVELS-1:0] le;
	logic [LEVELS-1:0] lt;

	always_comb begin
		for (int i = 0; i < LEVELS; i++) begin
			sel[i] = (lvl == LVL_W'(i + 1));
			le[i]  = (LVL_W'(i + 1) <= lvl);
			lt[i]  = (LVL_W'(i + 1) < lvl);
		end
	end

	always_comb begin : calc
		logic [LEVELS-1:0]   abits;
		logic [LEVELS-1:0]   flip;
		logic                fine;
		logic                seen;
		logic [KEY_BITS-1:0] sib;
		logic [KEY_BITS-1:0] face;
		for (int a = 0; a < AXES; a++) begin
			for (int i = 0; i < LEVELS; i++) begin
				abits[i] = node_key[bit_pos(i, a)];
			end
			fine = |(abits & sel);
			// scan from fine to coarse, flipping until the first differing level
			seen = 1'b0;
			for (int i = LEVELS - 1; i >= 0; i--) begin
				flip[i] = le[i] && !seen;
				seen    = seen | (lt[i] && (abits[i] ^ fine));
			end
			sib  = node_key;
			face = node_key;
			for (int i = 0; i < LEVELS; i++) begin
				sib[bit_pos(i, a)]  = sib[bit_pos(i, a)] ^ sel[i];
				face[bit_pos(i, a)] = face[bit_pos(i, a)] ^ flip[i];
			end
			res[a]            = '{key: sib, kind: KIND_SIBLING, axis: AXIS_W'(a)};
			res[AXES + a]     = '{key: face, kind: KIND_FACE, axis: AXIS_W'(a)};
			res_vld[a]        = 1'b1;
			// no differing level means domain wall or a single-level tree
			res_vld[AXES + a] = seen;
		end
	end

endmodule

/* rtl/octree_morton_neighbor_finder_unit.sv */
// ----------------------------------------------------------------------------
// octree_morton_neighbor_finder_unit
// Emits the sibling and face neighbor keys of each Morton node key.
// ----------------------------------------------------------------------------
// Input channel node_key_valid/node_key_stall carries one node key per
// transaction. For each key the output channel neighbor_valid/neighbor_stall
// gives three siblings (axes x, y, z) and then the face neighbors that exist,
// in axis order, with last set on the final one: 3 to 6 transactions.
// The user must write tree_level through tree_level_wr/tree_level_data only
// while idle; the block does not enforce it. Values of 0 act as 1 and values above 10 act as 10.
// With a free result bank a taken key passes from the input register into
// the result bank, which then offers its first neighbor.
// Throughput: one neighbor per cycle while neighbor_stall is low; a key
// occupies the result bank until its last neighbor is taken. The input
// register holds the next key meanwhile, so keys can follow back to back.
// Reset clears the input register and the result bank and sets tree_level
// to 1. A stall on the output holds the offered neighbor; once the input
// register is occupied the stall reaches back to node_key_stall.
// ----------------------------------------------------------------------------
module octree_morton_neighbor_finder_unit
	import omnf_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tree_level_wr,
	input  logic [LVL_W-1:0]    tree_level_data,
	input  logic                node_key_valid,
	output logic                node_key_stall,
	input  logic [KEY_BITS-1:0] node_key,
	output logic                neighbor_valid,
	input  logic                neighbor_stall,
	output logic [KEY_BITS-1:0] neighbor_key,
	output logic                neighbor_kind,
	output logic [AXIS_W-1:0]   axis,
	output logic                last
);

	logic [LVL_W-1:0]    level_q;
	logic [LVL_W-1:0]    lvl_eff;
	logic                vld_s1;
	logic [KEY_BITS-1:0] node_key_s1;
	result_t             bank_q [NUM_RES];
	logic [NUM_RES-1:0]  pend_q;
	result_t             calc_res [NUM_RES];
	logic [NUM_RES-1:0]  calc_vld;
	logic [NUM_RES-1:0]  cur_oh;
	logic [NUM_RES-1:0]  rest;
	result_t             cur;
	logic                fire;
	logic                bank_free;
	logic                load;
	logic                in_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= LVL_MIN;
		end else if (tree_level_wr) begin
			level_q <= tree_level_data;
		end
	end

	always_comb begin
		if (level_q < LVL_MIN) begin
			lvl_eff = LVL_MIN;
		end else if (level_q > LVL_MAX) begin
			lvl_eff = LVL_MAX;
		end else begin
			lvl_eff = level_q;
		end
	end

	omnf_nbr_calc u_calc (
		.node_key (node_key_s1),
		.lvl      (lvl_eff),
		.res      (calc_res),
		.res_vld  (calc_vld)
	);

	// oldest pending neighbor is the lowest set bit
	assign cur_oh    = pend_q & (~pend_q + NUM_RES'(1));
	assign rest      = pend_q & ~cur_oh;
	assign fire      = (|pend_q) && !neighbor_stall;
	assign bank_free = (pend_q == '0) || (fire && (rest == '0));
	assign load      = vld_s1 && bank_free;

	assign node_key_stall = vld_s1 && !load;
	assign in_fire        = node_key_valid && !node_key_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_fire) begin
			vld_s1 <= 1'b1;
		end else if (load) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			node_key_s1 <= node_key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (load) begin
			pend_q <= calc_vld;
		end else if (fire) begin
			pend_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < NUM_RES; i++) begin
				bank_q[i] <= calc_res[i];
			end
		end
	end

	always_comb begin
		cur = '0;
		for (int i = 0; i < NUM_RES; i++) begin
			if (cur_oh[i]) begin
				cur = bank_q[i];
			end
		end
	end

	assign neighbor_valid = |pend_q;
	assign neighbor_key   = cur.key;
	assign neighbor_kind  = cur.kind;
	assign axis           = cur.axis;
	assign last           = (rest == '0);

endmodule
